[hw/rtl/vsbdf_pkg.sv]
package vsbdf_pkg;

  localparam int MAX_ORDER_DEF    = 3;
  localparam int STEP_WIDTH_DEF   = 32;
  localparam int WEIGHT_WIDTH_DEF = 48;
  localparam int STEP_FRAC        = 24;
  localparam int WEIGHT_FRAC      = 24;
  localparam int FRAC_SHIFT       = STEP_FRAC + WEIGHT_FRAC;
  localparam logic [1:0] ORDER_RESET = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LD_A,
    ST_MS_B,
    ST_MR_B,
    ST_LD_C,
    ST_MS_D,
    ST_MR_D,
    ST_MS_E,
    ST_MR_E,
    ST_DV_S,
    ST_DV_R,
    ST_STORE,
    ST_SUM,
    ST_NEG,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_ONE,
    OP_D0,
    OP_D1,
    OP_D2,
    OP_S01,
    OP_S12,
    OP_S012,
    OP_TWO_D0_D1
  } op_e;

  typedef enum logic [2:0] {
    SLOT_A,
    SLOT_B,
    SLOT_C,
    SLOT_D,
    SLOT_E
  } slot_e;

  typedef struct packed {
    logic       hist_shift;
    logic       cfg_write;
    logic       clear;
    logic       load_acc;
    logic       mul_start;
    logic       mul_step;
    logic       num_latch;
    logic       div_start;
    logic       div_step;
    logic       store;
    logic       sum;
    logic       neg;
    logic       out_load;
    op_e        op;
    logic [1:0] k;
    logic       neg_w;
  } cmd_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       mb_zero;
    logic       div_last;
  } stat_t;

  // numerator is A*B, denominator is C*D*E
  function automatic op_e pick_op(input logic [1:0] cnt, input logic [1:0] k,
                                  input slot_e slot);
    op_e a;
    op_e b;
    op_e c;
    op_e d;
    op_e e;
    op_e r;
    a = OP_ONE;
    b = OP_ONE;
    c = OP_ONE;
    d = OP_ONE;
    e = OP_ONE;
    case ({cnt, k})
      {2'd3, 2'd1}: begin
        a = OP_S01; b = OP_S012; c = OP_D0; d = OP_D1; e = OP_S12;
      end
      {2'd3, 2'd2}: begin
        a = OP_D0; b = OP_S012; c = OP_D1; d = OP_D2; e = OP_S01;
      end
      {2'd3, 2'd3}: begin
        a = OP_D0; b = OP_S01; c = OP_D2; d = OP_S12; e = OP_S012;
      end
      {2'd2, 2'd0}: begin
        a = OP_TWO_D0_D1; c = OP_D0; d = OP_S01;
      end
      {2'd2, 2'd1}: begin
        a = OP_S01; c = OP_D0; d = OP_D1;
      end
      {2'd2, 2'd2}: begin
        a = OP_D0; c = OP_D1; d = OP_S01;
      end
      {2'd1, 2'd0}: begin
        c = OP_D0;
      end
      default: begin
        a = OP_ONE;
      end
    endcase
    case (slot)
      SLOT_A:  r = a;
      SLOT_B:  r = b;
      SLOT_C:  r = c;
      SLOT_D:  r = d;
      SLOT_E:  r = e;
      default: r = OP_ONE;
    endcase
    return r;
  endfunction

  function automatic logic is_neg(input logic [1:0] cnt, input logic [1:0] k);
    return (cnt == 2'd3 && (k == 2'd1 || k == 2'd3)) || (cnt == 2'd2 && k == 2'd1);
  endfunction

endpackage

[hw/rtl/vsbdf_ctrl.sv]
module vsbdf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vsbdf_pkg::stat_t    stat_i,
  output vsbdf_pkg::cmd_t     cmd_o
);

  vsbdf_pkg::state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] k_q, k_d;
  logic       out_valid_q, out_valid_d;
  logic       out_go;

  assign out_go      = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cfg_ready_o = (state_q == vsbdf_pkg::ST_IDLE);
  assign in_ready_o  = (state_q == vsbdf_pkg::ST_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    case (state_q)
      vsbdf_pkg::ST_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = vsbdf_pkg::ST_PREP;
      end
      vsbdf_pkg::ST_PREP: begin
        cnt_d = stat_i.cnt;
        k_d   = (stat_i.cnt == 2'd3) ? 2'd1 : 2'd0;
        state_d = (stat_i.cnt == 2'd0) ? vsbdf_pkg::ST_DONE : vsbdf_pkg::ST_LD_A;
      end
      vsbdf_pkg::ST_LD_A: state_d = vsbdf_pkg::ST_MS_B;
      vsbdf_pkg::ST_MS_B: state_d = vsbdf_pkg::ST_MR_B;
      vsbdf_pkg::ST_MR_B: begin
        if (stat_i.mb_zero) state_d = vsbdf_pkg::ST_LD_C;
      end
      vsbdf_pkg::ST_LD_C: state_d = vsbdf_pkg::ST_MS_D;
      vsbdf_pkg::ST_MS_D: state_d = vsbdf_pkg::ST_MR_D;
      vsbdf_pkg::ST_MR_D: begin
        if (stat_i.mb_zero) state_d = vsbdf_pkg::ST_MS_E;
      end
      vsbdf_pkg::ST_MS_E: state_d = vsbdf_pkg::ST_MR_E;
      vsbdf_pkg::ST_MR_E: begin
        if (stat_i.mb_zero) state_d = vsbdf_pkg::ST_DV_S;
      end
      vsbdf_pkg::ST_DV_S: state_d = vsbdf_pkg::ST_DV_R;
      vsbdf_pkg::ST_DV_R: begin
        if (stat_i.div_last) state_d = vsbdf_pkg::ST_STORE;
      end
      vsbdf_pkg::ST_STORE: begin
        k_d = k_q + 2'd1;
        case (cnt_q)
          2'd3:    state_d = (k_q == 2'd3) ? vsbdf_pkg::ST_SUM : vsbdf_pkg::ST_LD_A;
          2'd2:    state_d = (k_q == 2'd2) ? vsbdf_pkg::ST_DONE : vsbdf_pkg::ST_LD_A;
          default: state_d = vsbdf_pkg::ST_NEG;
        endcase
      end
      vsbdf_pkg::ST_SUM: state_d = vsbdf_pkg::ST_DONE;
      vsbdf_pkg::ST_NEG: state_d = vsbdf_pkg::ST_DONE;
      vsbdf_pkg::ST_DONE: begin
        if (out_go) state_d = vsbdf_pkg::ST_IDLE;
      end
      default: state_d = vsbdf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.op    = vsbdf_pkg::OP_ONE;
    cmd_o.k     = k_q;
    cmd_o.neg_w = vsbdf_pkg::is_neg(cnt_q, k_q);
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      vsbdf_pkg::ST_IDLE: begin
        cmd_o.hist_shift = in_valid_i && in_ready_o;
        cmd_o.cfg_write  = cfg_valid_i;
      end
      vsbdf_pkg::ST_PREP: cmd_o.clear = 1'b1;
      vsbdf_pkg::ST_LD_A: begin
        cmd_o.load_acc = 1'b1;
        cmd_o.op = vsbdf_pkg::pick_op(cnt_q, k_q, vsbdf_pkg::SLOT_A);
      end
      vsbdf_pkg::ST_MS_B: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op = vsbdf_pkg::pick_op(cnt_q, k_q, vsbdf_pkg::SLOT_B);
      end
      vsbdf_pkg::ST_MR_B: begin
        cmd_o.mul_step  = !stat_i.mb_zero;
        cmd_o.num_latch = stat_i.mb_zero;
      end
      vsbdf_pkg::ST_LD_C: begin
        cmd_o.load_acc = 1'b1;
        cmd_o.op = vsbdf_pkg::pick_op(cnt_q, k_q, vsbdf_pkg::SLOT_C);
      end
      vsbdf_pkg::ST_MS_D: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op = vsbdf_pkg::pick_op(cnt_q, k_q, vsbdf_pkg::SLOT_D);
      end
      vsbdf_pkg::ST_MR_D: cmd_o.mul_step = !stat_i.mb_zero;
      vsbdf_pkg::ST_MS_E: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.op = vsbdf_pkg::pick_op(cnt_q, k_q, vsbdf_pkg::SLOT_E);
      end
      vsbdf_pkg::ST_MR_E: cmd_o.mul_step = !stat_i.mb_zero;
      vsbdf_pkg::ST_DV_S: cmd_o.div_start = 1'b1;
      vsbdf_pkg::ST_DV_R: cmd_o.div_step = 1'b1;
      vsbdf_pkg::ST_STORE: cmd_o.store = 1'b1;
      vsbdf_pkg::ST_SUM: cmd_o.sum = 1'b1;
      vsbdf_pkg::ST_NEG: cmd_o.neg = 1'b1;
      vsbdf_pkg::ST_DONE: begin
        cmd_o.out_load = out_go;
        if (out_go) out_valid_d = 1'b1;
      end
      default: cmd_o.op = vsbdf_pkg::OP_ONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsbdf_pkg::ST_IDLE;
      cnt_q       <= 2'd0;
      k_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/vsbdf_dp.sv]
module vsbdf_dp #(
  parameter int MAX_ORDER    = vsbdf_pkg::MAX_ORDER_DEF,
  parameter int STEP_WIDTH   = vsbdf_pkg::STEP_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = vsbdf_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vsbdf_pkg::cmd_t                cmd_i,
  output vsbdf_pkg::stat_t               stat_o,
  input  logic [STEP_WIDTH-1:0]          step_size_i,
  input  logic [1:0]                     bdf_order_i,
  output logic signed [WEIGHT_WIDTH-1:0] weight_current_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_one_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_two_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_three_o,
  output logic [1:0]                     order_in_use_o,
  output logic                           saturated_o
);

  localparam int OW = STEP_WIDTH + 2;
  localparam int AW = 3 * OW;
  localparam int XW = AW + vsbdf_pkg::FRAC_SHIFT;
  localparam int WW = WEIGHT_WIDTH;
  localparam int CW = $clog2(WW + 1);
  localparam logic [1:0] MO2 = 2'(MAX_ORDER);
  localparam logic [WW:0] LIM = (WW + 1)'(1) << (WW - 1);
  localparam logic signed [WW-1:0] MAXPOS = {1'b0, {(WW - 1){1'b1}}};
  localparam logic signed [WW-1:0] MINNEG = {1'b1, {(WW - 1){1'b0}}};
  localparam logic signed [WW+1:0] MAXPOS_X = (WW + 2)'(MAXPOS);
  localparam logic signed [WW+1:0] MINNEG_X = -((WW + 2)'(LIM));

  logic [1:0]            order_q;
  logic [1:0]            act_ord;
  logic [STEP_WIDTH-1:0] hist_q [MAX_ORDER];
  logic [OW-1:0]         d_ext [3];
  logic [OW-1:0]         s01, s12, s012, two01, op_val;

  logic [AW-1:0] acc_q, mc_q, num_q;
  logic [OW-1:0] mb_q;

  logic [XW-1:0] x_full, x_hi;
  logic [AW-1:0] r_q;
  logic [WW-1:0] f_q, q_q;
  logic [CW-1:0] dcnt_q;
  logic          ovf_q, nz_q;
  logic [AW:0]   r2, r2_sub;
  logic          ge;
  logic          up;
  logic [WW:0]   qr;
  logic signed [WW-1:0] st_val;
  logic          st_sat;

  logic signed [WW-1:0] w_q [4];
  logic                 sat_q;
  logic signed [WW+1:0] sum_t;
  logic signed [WW-1:0] sum_val;
  logic                 sum_sat;

  always_comb begin
    act_ord = order_q;
    if (order_q == 2'd0) act_ord = 2'd1;
    if (order_q > MO2) act_ord = MO2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= vsbdf_pkg::ORDER_RESET;
      for (int i = 0; i < MAX_ORDER; i++) hist_q[i] <= '0;
    end else if (cmd_i.cfg_write) begin
      order_q <= bdf_order_i;
      for (int i = 0; i < MAX_ORDER; i++) hist_q[i] <= '0;
    end else if (cmd_i.hist_shift) begin
      hist_q[0] <= step_size_i;
      for (int i = 1; i < MAX_ORDER; i++) begin
        if (i < int'(act_ord)) hist_q[i] <= hist_q[i-1];
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_d
    if (j < MAX_ORDER) begin : g_on
      assign d_ext[j] = OW'(hist_q[j]);
    end else begin : g_off
      assign d_ext[j] = '0;
    end
  end

  assign s01   = d_ext[0] + d_ext[1];
  assign s12   = d_ext[1] + d_ext[2];
  assign s012  = s01 + d_ext[2];
  assign two01 = (d_ext[0] << 1) + d_ext[1];

  assign stat_o.cnt = 2'(d_ext[0] != '0) + 2'(d_ext[1] != '0) + 2'(d_ext[2] != '0);
  assign stat_o.mb_zero  = (mb_q == '0);
  assign stat_o.div_last = (dcnt_q == CW'(WW - 1));

  always_comb begin
    case (cmd_i.op)
      vsbdf_pkg::OP_ONE:       op_val = OW'(1);
      vsbdf_pkg::OP_D0:        op_val = d_ext[0];
      vsbdf_pkg::OP_D1:        op_val = d_ext[1];
      vsbdf_pkg::OP_D2:        op_val = d_ext[2];
      vsbdf_pkg::OP_S01:       op_val = s01;
      vsbdf_pkg::OP_S12:       op_val = s12;
      vsbdf_pkg::OP_S012:      op_val = s012;
      vsbdf_pkg::OP_TWO_D0_D1: op_val = two01;
      default:                 op_val = OW'(1);
    endcase
  end

  // shift-add multiplier, one multiplier bit per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_acc) begin
      acc_q <= AW'(op_val);
    end else if (cmd_i.mul_start) begin
      mc_q  <= acc_q;
      acc_q <= '0;
      mb_q  <= op_val;
    end else if (cmd_i.mul_step) begin
      if (mb_q[0]) acc_q <= acc_q + mc_q;
      mc_q <= mc_q << 1;
      mb_q <= mb_q >> 1;
    end
    if (cmd_i.num_latch) num_q <= acc_q;
  end

  // restoring divider, one quotient bit per cycle
  assign x_full = {num_q, {vsbdf_pkg::FRAC_SHIFT{1'b0}}};
  assign x_hi   = x_full >> WW;
  assign r2     = {r_q, f_q[WW-1]};
  assign r2_sub = r2 - {1'b0, acc_q};
  assign ge     = (r2 >= {1'b0, acc_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      r_q    <= x_hi[AW-1:0];
      f_q    <= x_full[WW-1:0];
      q_q    <= '0;
      dcnt_q <= '0;
      ovf_q  <= (x_hi >= XW'(acc_q));
      nz_q   <= (num_q != '0);
    end else if (cmd_i.div_step) begin
      r_q    <= ge ? r2_sub[AW-1:0] : r2[AW-1:0];
      q_q    <= {q_q[WW-2:0], ge};
      f_q    <= f_q << 1;
      dcnt_q <= dcnt_q + CW'(1);
    end
  end

  assign up = ({r_q, 1'b0} >= {1'b0, acc_q});
  assign qr = {1'b0, q_q} + (WW + 1)'(up);

  always_comb begin
    st_val = '0;
    st_sat = 1'b0;
    if (nz_q) begin
      if (cmd_i.neg_w) begin
        st_sat = ovf_q || (qr > LIM);
        st_val = st_sat ? MINNEG : -$signed(qr[WW-1:0]);
      end else begin
        st_sat = ovf_q || (qr >= LIM);
        st_val = st_sat ? MAXPOS : $signed(qr[WW-1:0]);
      end
    end
  end

  assign sum_t = -((WW + 2)'(w_q[1]) + (WW + 2)'(w_q[2]) + (WW + 2)'(w_q[3]));

  always_comb begin
    sum_sat = 1'b0;
    sum_val = sum_t[WW-1:0];
    if (sum_t > MAXPOS_X) begin
      sum_sat = 1'b1;
      sum_val = MAXPOS;
    end else if (sum_t < MINNEG_X) begin
      sum_sat = 1'b1;
      sum_val = MINNEG;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      for (int i = 0; i < 4; i++) w_q[i] <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.store) begin
      w_q[cmd_i.k] <= st_val;
      sat_q        <= sat_q | st_sat;
    end else if (cmd_i.sum) begin
      w_q[0] <= sum_val;
      sat_q  <= sat_q | sum_sat;
    end else if (cmd_i.neg) begin
      // a clipped first weight means the true magnitude reaches the negative limit
      w_q[1] <= sat_q ? MINNEG : -w_q[0];
    end
    if (cmd_i.out_load) begin
      weight_current_o    <= w_q[0];
      weight_back_one_o   <= w_q[1];
      weight_back_two_o   <= w_q[2];
      weight_back_three_o <= w_q[3];
      order_in_use_o      <= stat_o.cnt;
      saturated_o         <= sat_q;
    end
  end

endmodule

[hw/rtl/variable_step_bdf_weights.sv]
// channel | direction | handshake              | payload
// in      | input     | in_valid_i/in_ready_o   | step_size_i
// cfg     | input     | cfg_valid_i/cfg_ready_o | bdf_order_i
// out     | output    | out_valid_o/out_ready_i | weight_*_o, order_in_use_o, saturated_o
//
// one item at a time; up to three weights are computed per item, in turn, by the
// shift-add multiplier (one bit per cycle) and the restoring divider (one quotient
// bit per cycle), shared by all weights
// reset clears the order register to 3 and the step history to zero
// the next item is taken while a result waits on out; a stalled out holds the following result back
module variable_step_bdf_weights #(
  parameter int MAX_ORDER    = vsbdf_pkg::MAX_ORDER_DEF,
  parameter int STEP_WIDTH   = vsbdf_pkg::STEP_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = vsbdf_pkg::WEIGHT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [STEP_WIDTH-1:0]          step_size_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     bdf_order_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [WEIGHT_WIDTH-1:0] weight_current_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_one_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_two_o,
  output logic signed [WEIGHT_WIDTH-1:0] weight_back_three_o,
  output logic [1:0]                     order_in_use_o,
  output logic                           saturated_o
);

  vsbdf_pkg::cmd_t  cmd;
  vsbdf_pkg::stat_t stat;

  vsbdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  vsbdf_dp #(
    .MAX_ORDER    (MAX_ORDER),
    .STEP_WIDTH   (STEP_WIDTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .step_size_i         (step_size_i),
    .bdf_order_i         (bdf_order_i),
    .weight_current_o    (weight_current_o),
    .weight_back_one_o   (weight_back_one_o),
    .weight_back_two_o   (weight_back_two_o),
    .weight_back_three_o (weight_back_three_o),
    .order_in_use_o      (order_in_use_o),
    .saturated_o         (saturated_o)
  );

endmodule

[hw/rtl/vsbdf_checker.sv]
module vsbdf_checker #(
  parameter int STEP_WIDTH   = vsbdf_pkg::STEP_WIDTH_DEF,
  parameter int WEIGHT_WIDTH = vsbdf_pkg::WEIGHT_WIDTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic [STEP_WIDTH-1:0]          step_size_i,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o,
  input logic [1:0]                     bdf_order_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic signed [WEIGHT_WIDTH-1:0] weight_current_o,
  input logic signed [WEIGHT_WIDTH-1:0] weight_back_one_o,
  input logic signed [WEIGHT_WIDTH-1:0] weight_back_two_o,
  input logic signed [WEIGHT_WIDTH-1:0] weight_back_three_o,
  input logic [1:0]                     order_in_use_o,
  input logic                           saturated_o
);

  // block is busy right after taking a step
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !cfg_ready_o)
    else $error("ready after input transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(weight_current_o)
      && $stable(saturated_o) && $stable(order_in_use_o))
    else $error("stalled output transaction changed");

  a_order_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && order_in_use_o == 2'd0 |-> weight_current_o == '0
      && weight_back_one_o == '0 && weight_back_two_o == '0 && !saturated_o)
    else $error("nonzero weights with no history");

  a_back_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && order_in_use_o != 2'd3 |-> weight_back_three_o == '0)
    else $error("third back weight set below order three");

  // clipped weights sit at opposite limits, which are not exact negations
  a_order_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && order_in_use_o == 2'd1 |-> (saturated_o
      || weight_back_one_o == -weight_current_o) && weight_back_two_o == '0)
    else $error("order one weights not opposite");

endmodule

bind variable_step_bdf_weights vsbdf_checker #(
  .STEP_WIDTH   (STEP_WIDTH),
  .WEIGHT_WIDTH (WEIGHT_WIDTH)
) u_vsbdf_checker (.*);
